FILE: src/fas_pkg.sv
// fas_pkg: types, codes and constants shared by the frame asphericity statistics block
// depends on nothing; fas_datapath, fas_ctrl and the top file use it by scoped names
`default_nettype none

package fas_pkg;

    localparam logic [28:0] INV4PI = 29'd341782638;
    localparam logic [31:0] SAT32  = 32'hFFFF_FFFF;

    localparam logic [1:0] CFG_POINTS = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    typedef struct packed {
        logic [31:0] frame_time;
        logic [31:0] perimeter;
        logic [31:0] area;
    } t_fas_in;

    typedef struct packed {
        logic [31:0] out_time;
        logic [31:0] mean_value;
        logic [31:0] std_dev;
        logic [31:0] std_err;
    } t_fas_out;

    typedef struct packed {
        logic [15:0] points_per_frame;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } t_fas_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQR, ST_MLO, ST_MHI, ST_CHK, ST_DIVQ, ST_SQ, ST_ACC,
        ST_DIVM, ST_DIVMS, ST_MM0, ST_MM1, ST_MM2, ST_DIFF, ST_STV, ST_DIVV,
        ST_RT1, ST_WSD, ST_EMIT
    } t_fas_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQR, OP_MLO, OP_MHI, OP_CHK, OP_GETQ, OP_SQ,
        OP_ACC, OP_GETM, OP_GETMS, OP_MM0, OP_MM1, OP_MM2, OP_DIFF, OP_STV,
        OP_GETV, OP_RT1, OP_GETSD, OP_EMIT
    } t_fas_op;

    typedef struct packed {
        t_fas_op op;
        logic    div_go;
        logic    sqrt_go;
    } t_fas_cmd;

    typedef struct packed {
        logic q_sat;
        logic frame_end;
        logic early;
        logic late;
        logic var_big;
        logic se_sat;
        logic div_busy;
        logic sqrt_busy;
    } t_fas_sts;

endpackage

`default_nettype wire

FILE: src/fas_div.sv
// fas_div: iterative 64 by 32 bit unsigned divider, two quotient bits per cycle
// depends on nothing; used by fas_datapath
`default_nettype none

module fas_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic [63:0]      o_quot
);

    localparam logic [4:0] LAST = 5'd31;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_dvd;
    logic [31:0] r_dsr;

    logic [32:0] w_s1, w_s2, w_d1, w_d2;
    logic        w_ge1, w_ge2;
    logic [31:0] w_rem1, w_rem2;

    always_comb begin
        w_s1   = {r_rem, r_dvd[63]};
        w_ge1  = w_s1 >= {1'b0, r_dsr};
        w_d1   = w_s1 - {1'b0, r_dsr};
        w_rem1 = w_ge1 ? w_d1[31:0] : w_s1[31:0];
        w_s2   = {w_rem1, r_dvd[62]};
        w_ge2  = w_s2 >= {1'b0, r_dsr};
        w_d2   = w_s2 - {1'b0, r_dsr};
        w_rem2 = w_ge2 ? w_d2[31:0] : w_s2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[61:0], w_ge1, w_ge2};
            r_rem <= w_rem2;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

FILE: src/fas_sqrt.sv
// fas_sqrt: iterative 64 bit integer square root, one root bit per cycle
// depends on nothing; used by fas_datapath
`default_nettype none

module fas_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_rad,
    output logic             o_busy,
    output logic [31:0]      o_root
);

    localparam logic [4:0] LAST = 5'd31;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] w_s, w_trial, w_diff;
    logic        w_ge;

    always_comb begin
        w_s     = {r_rem, r_rad[63:62]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = w_s >= w_trial;
        w_diff  = w_s - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_ge ? w_diff[33:0] : w_s[33:0];
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: src/fas_datapath.sv
// fas_datapath: asphericity arithmetic, running sums, frame statistics, result register
// depends on fas_pkg, fas_div and fas_sqrt; driven by commands from fas_ctrl
`default_nettype none

module fas_datapath #(
    parameter int unsigned MAX_POINTS = 65535
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fas_pkg::t_fas_cmd i_cmd,
    output fas_pkg::t_fas_sts      o_sts,
    input  wire fas_pkg::t_fas_cfg i_cfg,
    input  wire fas_pkg::t_fas_in  i_in_word,
    output fas_pkg::t_fas_out      o_out_word
);

    localparam logic [16:0] MAXP = 17'(MAX_POINTS);

    fas_pkg::t_fas_in  r_in;
    fas_pkg::t_fas_out r_out;
    logic [63:0] r_t64;
    logic [60:0] r_plo;
    logic [92:0] r_prod;
    logic [31:0] r_q;
    logic [47:0] r_sq;
    logic [15:0] r_index;
    logic [47:0] r_sum;
    logic [63:0] r_ssum;
    logic [63:0] r_fss;
    logic [16:0] r_cnt;
    logic [47:0] r_mean;
    logic [63:0] r_msq;
    logic [63:0] r_acc;
    logic [63:0] r_d;
    logic [63:0] r_var;
    logic [31:0] r_sd;

    logic [63:0] w_pp, w_qq;
    logic [60:0] w_phi;
    logic [47:0] w_mm;
    logic [48:0] w_s49;
    logic [64:0] w_ss65;
    logic [47:0] w_nsum;
    logic [63:0] w_nssum;
    logic [16:0] w_c, w_n;
    logic [63:0] w_msq2;
    logic        w_var_big, w_se_sat;

    logic        w_div_busy, w_sqrt_busy;
    logic [63:0] w_quot, w_dvd, w_rad;
    logic [31:0] w_dsr, w_root;

    always_comb begin
        w_pp   = {32'b0, r_in.perimeter} * {32'b0, r_in.perimeter};
        w_phi  = {29'b0, r_t64[63:32]} * {32'b0, fas_pkg::INV4PI};
        w_qq   = {32'b0, r_q} * {32'b0, r_q};
        w_mm   = '0;
        case (i_cmd.op)
            fas_pkg::OP_MM0: w_mm = {24'b0, r_mean[23:0]} * {24'b0, r_mean[23:0]};
            fas_pkg::OP_MM1: w_mm = {24'b0, r_mean[47:24]} * {24'b0, r_mean[23:0]};
            fas_pkg::OP_MM2: w_mm = {24'b0, r_mean[47:24]} * {24'b0, r_mean[47:24]};
            default:         w_mm = '0;
        endcase
        w_s49   = {1'b0, r_sum} + {17'b0, r_q};
        w_nsum  = w_s49[48] ? {48{1'b1}} : w_s49[47:0];
        w_ss65  = {1'b0, r_ssum} + {17'b0, r_sq};
        w_nssum = w_ss65[64] ? {64{1'b1}} : w_ss65[63:0];
        w_c     = {1'b0, r_index} + 17'd1;
        if (i_cfg.points_per_frame < 16'd2) begin
            w_n = 17'd2;
        end else if (32'(i_cfg.points_per_frame) > MAX_POINTS) begin
            w_n = MAXP;
        end else begin
            w_n = {1'b0, i_cfg.points_per_frame};
        end
        w_msq2    = {16'b0, r_acc[63:16]};
        w_var_big = r_var[63:48] != 16'b0;
        w_se_sat  = w_var_big && (w_quot[63:48] != 16'b0);
    end

    always_comb begin
        w_dvd = '0;
        w_dsr = 32'd1;
        w_rad = '0;
        case (i_cmd.op)
            fas_pkg::OP_CHK: begin
                w_dvd = r_prod[87:24];
                w_dsr = r_in.area;
            end
            fas_pkg::OP_ACC: begin
                w_dvd = {16'b0, w_nsum};
                w_dsr = {15'b0, w_c};
            end
            fas_pkg::OP_GETM: begin
                w_dvd = r_fss;
                w_dsr = {15'b0, r_cnt};
            end
            fas_pkg::OP_STV: begin
                w_dvd = r_d;
                w_dsr = {15'b0, r_cnt - 17'd1};
            end
            fas_pkg::OP_RT1: begin
                w_dvd = w_var_big ? r_var : {r_var[47:0], 16'b0};
                w_dsr = {15'b0, r_cnt};
                w_rad = {r_var[47:0], 16'b0};
            end
            fas_pkg::OP_GETSD: begin
                w_rad = w_var_big ? {w_quot[47:0], 16'b0} : w_quot;
            end
            default: begin
                w_dvd = '0;
            end
        endcase
    end

    fas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    fas_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_rad   (w_rad),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    // frame counter and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_sum   <= '0;
            r_ssum  <= '0;
        end else if (i_cmd.op == fas_pkg::OP_ACC) begin
            if (w_c < w_n) begin
                r_index <= w_c[15:0];
                r_sum   <= w_nsum;
                r_ssum  <= w_nssum;
            end else begin
                r_index <= '0;
                r_sum   <= '0;
                r_ssum  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fas_pkg::OP_LOAD: r_in   <= i_in_word;
            fas_pkg::OP_SQR:  r_t64  <= w_pp;
            fas_pkg::OP_MLO:  r_plo  <= {29'b0, r_t64[31:0]} * {32'b0, fas_pkg::INV4PI};
            fas_pkg::OP_MHI:  r_prod <= {32'b0, r_plo} + {w_phi, 32'b0};
            fas_pkg::OP_CHK: begin
                if (o_sts.q_sat) begin
                    r_q <= fas_pkg::SAT32;
                end
            end
            fas_pkg::OP_GETQ: r_q  <= w_quot[31:0];
            fas_pkg::OP_SQ:   r_sq <= w_qq[63:16];
            fas_pkg::OP_ACC: begin
                r_fss <= w_nssum;
                r_cnt <= w_c;
            end
            fas_pkg::OP_GETM:  r_mean <= w_quot[47:0];
            fas_pkg::OP_GETMS: r_msq  <= w_quot;
            fas_pkg::OP_MM0:   r_acc  <= {16'b0, w_mm};
            fas_pkg::OP_MM1:   r_acc  <= r_acc + {w_mm[38:0], 25'b0};
            fas_pkg::OP_MM2:   r_acc  <= r_acc + {w_mm[15:0], 48'b0};
            fas_pkg::OP_DIFF:  r_d    <= (r_msq > w_msq2) ? (r_msq - w_msq2) : 64'b0;
            fas_pkg::OP_GETV:  r_var  <= r_d + w_quot;
            fas_pkg::OP_GETSD: r_sd   <= w_var_big ? fas_pkg::SAT32 : w_root;
            fas_pkg::OP_EMIT: begin
                r_out.out_time   <= r_in.frame_time;
                r_out.mean_value <= r_mean[31:0];
                r_out.std_dev    <= r_sd;
                r_out.std_err    <= w_se_sat ? fas_pkg::SAT32 : w_root;
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    always_comb begin
        o_sts.q_sat     = (r_in.area == 32'b0) || (r_prod[92:88] != 5'b0)
                          || (r_prod[87:56] >= r_in.area);
        o_sts.frame_end = !(w_c < w_n);
        o_sts.early     = r_in.frame_time < i_cfg.start_time;
        o_sts.late      = r_in.frame_time > i_cfg.end_time;
        o_sts.var_big   = w_var_big;
        o_sts.se_sat    = w_se_sat;
        o_sts.div_busy  = w_div_busy;
        o_sts.sqrt_busy = w_sqrt_busy;
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

FILE: src/fas_ctrl.sv
// fas_ctrl: sequencer for one sample and the end-of-frame statistics, plus handshakes
// depends on fas_pkg; drives fas_datapath through command and status structs
`default_nettype none

module fas_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire fas_pkg::t_fas_sts i_sts,
    output fas_pkg::t_fas_cmd      o_cmd
);

    fas_pkg::t_fas_state r_state, n_state;
    logic r_halted, n_halted;
    logic r_out_valid, n_out_valid;
    logic w_emit;

    assign w_emit = (r_state == fas_pkg::ST_EMIT) && !i_sts.sqrt_busy
                    && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fas_pkg::ST_IDLE;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fas_pkg::ST_IDLE: begin
                if (i_in_valid && !r_halted) begin
                    n_state = fas_pkg::ST_SQR;
                end
            end
            fas_pkg::ST_SQR: n_state = fas_pkg::ST_MLO;
            fas_pkg::ST_MLO: n_state = fas_pkg::ST_MHI;
            fas_pkg::ST_MHI: n_state = fas_pkg::ST_CHK;
            fas_pkg::ST_CHK: n_state = i_sts.q_sat ? fas_pkg::ST_SQ : fas_pkg::ST_DIVQ;
            fas_pkg::ST_DIVQ: begin
                if (!i_sts.div_busy) begin
                    n_state = fas_pkg::ST_SQ;
                end
            end
            fas_pkg::ST_SQ: n_state = fas_pkg::ST_ACC;
            fas_pkg::ST_ACC: begin
                if (i_sts.frame_end && !i_sts.early && !i_sts.late) begin
                    n_state = fas_pkg::ST_DIVM;
                end else begin
                    n_state = fas_pkg::ST_IDLE;
                end
            end
            fas_pkg::ST_DIVM: begin
                if (!i_sts.div_busy) begin
                    n_state = fas_pkg::ST_DIVMS;
                end
            end
            fas_pkg::ST_DIVMS: begin
                if (!i_sts.div_busy) begin
                    n_state = fas_pkg::ST_MM0;
                end
            end
            fas_pkg::ST_MM0:  n_state = fas_pkg::ST_MM1;
            fas_pkg::ST_MM1:  n_state = fas_pkg::ST_MM2;
            fas_pkg::ST_MM2:  n_state = fas_pkg::ST_DIFF;
            fas_pkg::ST_DIFF: n_state = fas_pkg::ST_STV;
            fas_pkg::ST_STV:  n_state = fas_pkg::ST_DIVV;
            fas_pkg::ST_DIVV: begin
                if (!i_sts.div_busy) begin
                    n_state = fas_pkg::ST_RT1;
                end
            end
            fas_pkg::ST_RT1: n_state = fas_pkg::ST_WSD;
            fas_pkg::ST_WSD: begin
                if (!i_sts.div_busy && !i_sts.sqrt_busy) begin
                    n_state = fas_pkg::ST_EMIT;
                end
            end
            fas_pkg::ST_EMIT: begin
                if (w_emit) begin
                    n_state = fas_pkg::ST_IDLE;
                end
            end
            default: n_state = fas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op      = fas_pkg::OP_NONE;
        o_cmd.div_go  = 1'b0;
        o_cmd.sqrt_go = 1'b0;
        n_halted      = r_halted;
        n_out_valid   = r_out_valid && i_out_stall;
        case (r_state)
            fas_pkg::ST_IDLE: begin
                if (i_in_valid && !r_halted) begin
                    o_cmd.op = fas_pkg::OP_LOAD;
                end
            end
            fas_pkg::ST_SQR: o_cmd.op = fas_pkg::OP_SQR;
            fas_pkg::ST_MLO: o_cmd.op = fas_pkg::OP_MLO;
            fas_pkg::ST_MHI: o_cmd.op = fas_pkg::OP_MHI;
            fas_pkg::ST_CHK: begin
                o_cmd.op     = fas_pkg::OP_CHK;
                o_cmd.div_go = !i_sts.q_sat;
            end
            fas_pkg::ST_DIVQ: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = fas_pkg::OP_GETQ;
                end
            end
            fas_pkg::ST_SQ: o_cmd.op = fas_pkg::OP_SQ;
            fas_pkg::ST_ACC: begin
                o_cmd.op     = fas_pkg::OP_ACC;
                o_cmd.div_go = i_sts.frame_end && !i_sts.early && !i_sts.late;
                if (i_sts.frame_end && !i_sts.early && i_sts.late) begin
                    n_halted = 1'b1;
                end
            end
            fas_pkg::ST_DIVM: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op     = fas_pkg::OP_GETM;
                    o_cmd.div_go = 1'b1;
                end
            end
            fas_pkg::ST_DIVMS: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = fas_pkg::OP_GETMS;
                end
            end
            fas_pkg::ST_MM0:  o_cmd.op = fas_pkg::OP_MM0;
            fas_pkg::ST_MM1:  o_cmd.op = fas_pkg::OP_MM1;
            fas_pkg::ST_MM2:  o_cmd.op = fas_pkg::OP_MM2;
            fas_pkg::ST_DIFF: o_cmd.op = fas_pkg::OP_DIFF;
            fas_pkg::ST_STV: begin
                o_cmd.op     = fas_pkg::OP_STV;
                o_cmd.div_go = 1'b1;
            end
            fas_pkg::ST_DIVV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = fas_pkg::OP_GETV;
                end
            end
            fas_pkg::ST_RT1: begin
                o_cmd.op      = fas_pkg::OP_RT1;
                o_cmd.div_go  = 1'b1;
                o_cmd.sqrt_go = !i_sts.var_big;
            end
            fas_pkg::ST_WSD: begin
                if (!i_sts.div_busy && !i_sts.sqrt_busy) begin
                    o_cmd.op      = fas_pkg::OP_GETSD;
                    o_cmd.sqrt_go = !i_sts.se_sat;
                end
            end
            fas_pkg::ST_EMIT: begin
                if (w_emit) begin
                    o_cmd.op    = fas_pkg::OP_EMIT;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.op = fas_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall  = r_state != fas_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sqrt_go |-> !i_sts.sqrt_busy)
        else $error("square root unit started while busy");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    a_halt_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fas_pkg::ST_IDLE && i_in_valid && r_halted)
        |=> (r_state == fas_pkg::ST_IDLE))
        else $error("word processed while halted");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fas_pkg::ST_EMIT && r_out_valid && i_out_stall)
        |=> (r_state == fas_pkg::ST_EMIT))
        else $error("result overwrote a word still held");

endmodule

`default_nettype wire

FILE: src/frame_asphericity_statistics.sv
// frame asphericity statistics: one shape word in, one statistics word per reported frame
// a sample's time is set mostly by the shared divider, which a saturated quotient skips
// a reported frame end adds four divider runs and up to two square root runs
// one word is in work at a time; a result waits in the output register while the next is taken
// reset is synchronous active low: configuration to defaults, sums and frame count cleared
// depends on fas_pkg, fas_ctrl, fas_datapath
`default_nettype none

module frame_asphericity_statistics #(
    parameter int unsigned MAX_POINTS = 65535
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fas_pkg::t_fas_in i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output fas_pkg::t_fas_out     o_out_word,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data
);

    fas_pkg::t_fas_cfg r_cfg;
    fas_pkg::t_fas_cmd w_cmd;
    fas_pkg::t_fas_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.points_per_frame <= 16'd2;
            r_cfg.start_time       <= 32'd0;
            r_cfg.end_time         <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fas_pkg::CFG_POINTS: r_cfg.points_per_frame <= i_cfg_data[15:0];
                fas_pkg::CFG_START:  r_cfg.start_time       <= i_cfg_data;
                fas_pkg::CFG_END:    r_cfg.end_time         <= i_cfg_data;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    fas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fas_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg      (r_cfg),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
